// ----- design/dchc_pkg.sv -----
// ----------------------------------------------------------------------------
// dchc_pkg - shared constants for the duty-cycle and hop controller
// Item opcodes, phase codes, hop modes, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package dchc_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int WORD_W   = 32;
    localparam int FREQ_W   = 33;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 33;

    // Remainder unit: 34-bit dividend and divisor, one bit per cycle
    localparam int REM_W     = 34;
    localparam int REM_CNT_W = 6;

    // Signed sweep arithmetic width
    localparam int SWP_W = 36;

    typedef logic [FREQ_W-1:0] t_freq;

    localparam t_freq FREQ_SAT = '1;

    // Item opcodes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    // Phase codes
    localparam logic [1:0] PH_STOPPED = 2'd0;
    localparam logic [1:0] PH_ON      = 2'd1;
    localparam logic [1:0] PH_OFF     = 2'd2;

    // Hop modes
    localparam logic [1:0] HOP_FIXED  = 2'd0;
    localparam logic [1:0] HOP_SWEEP  = 2'd1;
    localparam logic [1:0] HOP_RANDOM = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_STEP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_BW      = 3'd7;

    // Reset values
    localparam logic [WORD_W-1:0] RST_ON_TICKS    = 32'd1000;
    localparam logic [WORD_W-1:0] RST_OFF_TICKS   = 32'd0;
    localparam logic [WORD_W-1:0] RST_DWELL_TICKS = 32'd1000;
    localparam t_freq             RST_FREQ        = 33'd765000000;
    localparam logic [WORD_W-1:0] RST_FREQ_STEP   = 32'd1000000;
    localparam logic [WORD_W-1:0] RST_HOP_BW      = 32'd0;

endpackage

// ----- design/duty_cycle_hop_controller.sv -----
// ----------------------------------------------------------------------------
// duty_cycle_hop_controller - burst and frequency hop controller
// Duty-cycle on/off phasing with burst flags, and sweep or random hopping.
// ----------------------------------------------------------------------------
// Each input word is a tick, a start or a stop, and produces exactly one
// result word with the phase, burst flags and current frequency. The block
// handles one word at a time: o_in_ready is high only while the sequencer
// is idle. A start, stop, plain tick or tick without a hop goes straight to
// ST_DONE; a sweep hop passes ST_SWP2 first. A random hop waits in ST_MOD1
// and ST_MOD2 on the shared remainder unit, which runs twice at one bit
// per cycle over 34 bits: first random_word mod hop_bandwidth, then
// (2r + step) mod (2 * step), from which the rounded offset follows without
// a multiplier. A finished result sits in the output register, and the next
// input word is taken while it waits. Configuration is written through its
// own port at any time it is offered; it must only be changed while idle.
// ----------------------------------------------------------------------------
module duty_cycle_hop_controller #(
    parameter int TICK_COUNT_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [dchc_pkg::OP_W-1:0]        i_opcode,
    input  logic [dchc_pkg::WORD_W-1:0]      i_random_word,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_transmitting,
    output logic                             o_burst_start,
    output logic                             o_burst_end,
    output logic [dchc_pkg::FREQ_W-1:0]      o_frequency,
    output logic                             o_freq_changed,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dchc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dchc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CNT_W = TICK_COUNT_WIDTH;
    localparam int CMP_W = (TICK_COUNT_WIDTH > 32) ? TICK_COUNT_WIDTH : 32;
    localparam int REM_W = dchc_pkg::REM_W;
    localparam int SWP_W = dchc_pkg::SWP_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD1 = 3'd1;
    localparam logic [2:0] ST_MOD2 = 3'd2;
    localparam logic [2:0] ST_SWP1 = 3'd3;
    localparam logic [2:0] ST_SWP2 = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // ---------------- configuration registers ----------------
    logic [31:0]           r_on_ticks;
    logic [31:0]           r_off_ticks;
    logic [31:0]           r_dwell_ticks;
    logic [1:0]            r_hop_mode;
    dchc_pkg::t_freq       r_freq_min;
    dchc_pkg::t_freq       r_freq_max;
    logic [31:0]           r_freq_step;
    logic [31:0]           r_hop_bw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_ticks    <= dchc_pkg::RST_ON_TICKS;
            r_off_ticks   <= dchc_pkg::RST_OFF_TICKS;
            r_dwell_ticks <= dchc_pkg::RST_DWELL_TICKS;
            r_hop_mode    <= dchc_pkg::HOP_FIXED;
            r_freq_min    <= dchc_pkg::RST_FREQ;
            r_freq_max    <= dchc_pkg::RST_FREQ;
            r_freq_step   <= dchc_pkg::RST_FREQ_STEP;
            r_hop_bw      <= dchc_pkg::RST_HOP_BW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dchc_pkg::CFG_ON_TICKS:    r_on_ticks    <= i_cfg_data[31:0];
                dchc_pkg::CFG_OFF_TICKS:   r_off_ticks   <= i_cfg_data[31:0];
                dchc_pkg::CFG_DWELL_TICKS: r_dwell_ticks <= i_cfg_data[31:0];
                dchc_pkg::CFG_HOP_MODE:    r_hop_mode    <= i_cfg_data[1:0];
                dchc_pkg::CFG_FREQ_MIN:    r_freq_min    <= i_cfg_data;
                dchc_pkg::CFG_FREQ_MAX:    r_freq_max    <= i_cfg_data;
                dchc_pkg::CFG_FREQ_STEP:   r_freq_step   <= i_cfg_data[31:0];
                dchc_pkg::CFG_HOP_BW:      r_hop_bw      <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // ---------------- controller state ----------------
    logic [2:0]             r_state,   n_state;
    logic [1:0]             r_phase,   n_phase;
    logic [CNT_W-1:0]       r_pcount,  n_pcount;
    logic [CNT_W-1:0]       r_dcount,  n_dcount;
    dchc_pkg::t_freq        r_freq,    n_freq;
    logic                   r_down,    n_down;
    logic                   r_bstart,  n_bstart;
    logic                   r_bend,    n_bend;
    logic                   r_changed, n_changed;
    logic [REM_W-1:0]       r_t,       n_t;
    logic signed [SWP_W-1:0] r_f,      n_f;
    logic                   r_out_valid, n_out_valid;

    // result register
    logic                   r_out_tx;
    logic                   r_out_bstart;
    logic                   r_out_bend;
    dchc_pkg::t_freq        r_out_freq;
    logic                   r_out_changed;

    // remainder unit hookup
    logic                   w_rem_start;
    logic [REM_W-1:0]       w_rem_dividend;
    logic [REM_W-1:0]       w_rem_divisor;
    logic                   w_rem_done;
    logic [REM_W-1:0]       w_rem;

    // tick evaluation
    logic                   w_accept;
    logic [CNT_W-1:0]       w_pc_inc;
    logic [CNT_W-1:0]       w_dc_inc;
    logic                   w_hop;
    logic [1:0]             w_ph;
    logic [CNT_W-1:0]       w_pc;
    logic                   w_tick_bstart;
    logic                   w_tick_bend;

    // hop arithmetic
    logic [REM_W-1:0]       w_t;
    logic [REM_W-1:0]       w_t_diff;
    logic [dchc_pkg::FREQ_W:0] w_rand_sum;
    logic signed [SWP_W-1:0] w_step;
    logic signed [SWP_W-1:0] w_step2;
    logic signed [SWP_W-1:0] w_cur;
    logic signed [SWP_W-1:0] w_min;
    logic signed [SWP_W-1:0] w_max;
    logic                   w_out_rng;
    logic                   w_new_down;
    logic signed [SWP_W-1:0] w_f2;
    logic                   w_out_free;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // saturating counts, then duty-cycle phase walk (off_ticks of zero
    // lets a burst end and restart on the same tick)
    always_comb begin
        w_pc_inc = (r_pcount == '1) ? r_pcount : r_pcount + 1'b1;
        w_dc_inc = (r_dcount == '1) ? r_dcount : r_dcount + 1'b1;
        w_hop    = (r_hop_mode == dchc_pkg::HOP_SWEEP ||
                    r_hop_mode == dchc_pkg::HOP_RANDOM) &&
                   (CMP_W'(w_dc_inc) >= CMP_W'(r_dwell_ticks));
        w_ph          = r_phase;
        w_pc          = w_pc_inc;
        w_tick_bstart = 1'b0;
        w_tick_bend   = 1'b0;
        if (w_ph == dchc_pkg::PH_ON && CMP_W'(w_pc) >= CMP_W'(r_on_ticks)) begin
            w_ph        = dchc_pkg::PH_OFF;
            w_pc        = '0;
            w_tick_bend = 1'b1;
        end
        if (w_ph == dchc_pkg::PH_OFF && CMP_W'(w_pc) >= CMP_W'(r_off_ticks)) begin
            w_ph          = dchc_pkg::PH_ON;
            w_pc          = '0;
            w_tick_bstart = 1'b1;
        end
    end

    // random hop: offset = ((2r + s) - ((2r + s) mod 2s)) / 2
    always_comb begin
        w_t        = {1'b0, w_rem[31:0], 1'b0} + {2'b0, r_freq_step};
        w_t_diff   = r_t - w_rem;
        w_rand_sum = {1'b0, r_freq_min} + {1'b0, w_t_diff[REM_W-1:1]};
    end

    // sweep: step, and on leaving [min, max] reverse with twice the step
    always_comb begin
        w_step     = $signed({4'b0, r_freq_step});
        w_step2    = $signed({3'b0, r_freq_step, 1'b0});
        w_cur      = $signed({3'b0, r_freq});
        w_min      = $signed({3'b0, r_freq_min});
        w_max      = $signed({3'b0, r_freq_max});
        w_out_rng  = (r_f > w_max) || (r_f < w_min);
        w_new_down = w_out_rng ? !r_down : r_down;
        if (!w_out_rng) begin
            w_f2 = r_f;
        end else if (w_new_down) begin
            w_f2 = r_f - w_step2;
        end else begin
            w_f2 = r_f + w_step2;
        end
    end

    assign w_rem_dividend = (r_state == ST_IDLE) ? {2'b0, i_random_word} : w_t;
    assign w_rem_divisor  = (r_state == ST_IDLE) ? {2'b0, r_hop_bw}
                                                 : {1'b0, r_freq_step, 1'b0};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_pcount    = r_pcount;
        n_dcount    = r_dcount;
        n_freq      = r_freq;
        n_down      = r_down;
        n_bstart    = r_bstart;
        n_bend      = r_bend;
        n_changed   = r_changed;
        n_t         = r_t;
        n_f         = r_f;
        n_out_valid = r_out_valid;
        w_rem_start = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_bstart  = 1'b0;
                    n_bend    = 1'b0;
                    n_changed = 1'b0;
                    n_state   = ST_DONE;
                    case (i_opcode)
                        dchc_pkg::OP_START: begin
                            n_phase  = dchc_pkg::PH_ON;
                            n_pcount = '0;
                            n_dcount = '0;
                            n_bstart = 1'b1;
                        end
                        dchc_pkg::OP_STOP: begin
                            n_phase = dchc_pkg::PH_STOPPED;
                        end
                        dchc_pkg::OP_TICK: begin
                            if (r_phase != dchc_pkg::PH_STOPPED) begin
                                n_phase   = w_ph;
                                n_pcount  = w_pc;
                                n_dcount  = w_hop ? '0 : w_dc_inc;
                                n_bstart  = w_tick_bstart;
                                n_bend    = w_tick_bend;
                                n_changed = w_hop;
                                if (w_hop && r_hop_mode == dchc_pkg::HOP_SWEEP) begin
                                    n_f     = r_down ? w_cur - w_step : w_cur + w_step;
                                    n_state = ST_SWP2;
                                end else if (w_hop) begin
                                    if (r_hop_bw == '0 || r_freq_step == '0) begin
                                        n_freq = r_freq_min;
                                    end else begin
                                        w_rem_start = 1'b1;
                                        n_state     = ST_MOD1;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOD1: begin
                if (w_rem_done) begin
                    n_t         = w_t;
                    w_rem_start = 1'b1;
                    n_state     = ST_MOD2;
                end
            end
            ST_MOD2: begin
                if (w_rem_done) begin
                    n_freq  = w_rand_sum[dchc_pkg::FREQ_W] ? dchc_pkg::FREQ_SAT
                                                           : w_rand_sum[dchc_pkg::FREQ_W-1:0];
                    n_state = ST_DONE;
                end
            end
            ST_SWP1: begin
                n_state = ST_SWP2;
            end
            ST_SWP2: begin
                n_down = w_new_down;
                if (w_f2 < 0) begin
                    n_freq = '0;
                end else if (w_f2 > $signed({3'b0, dchc_pkg::FREQ_SAT})) begin
                    n_freq = dchc_pkg::FREQ_SAT;
                end else begin
                    n_freq = w_f2[dchc_pkg::FREQ_W-1:0];
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= dchc_pkg::PH_STOPPED;
            r_pcount    <= '0;
            r_dcount    <= '0;
            r_freq      <= dchc_pkg::RST_FREQ;
            r_down      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pcount    <= n_pcount;
            r_dcount    <= n_dcount;
            r_freq      <= n_freq;
            r_down      <= n_down;
            r_out_valid <= n_out_valid;
        end
    end

    // per-word scratch and result payload
    always_ff @(posedge i_clk) begin
        r_bstart  <= n_bstart;
        r_bend    <= n_bend;
        r_changed <= n_changed;
        r_t       <= n_t;
        r_f       <= n_f;
        if (r_state == ST_DONE && w_out_free) begin
            r_out_tx      <= (r_phase == dchc_pkg::PH_ON);
            r_out_bstart  <= r_bstart;
            r_out_bend    <= r_bend;
            r_out_freq    <= r_freq;
            r_out_changed <= r_changed;
        end
    end

    dchc_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_rem_dividend),
        .i_divisor  (w_rem_divisor),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_transmitting = r_out_tx;
    assign o_burst_start  = r_out_bstart;
    assign o_burst_end    = r_out_bend;
    assign o_frequency    = r_out_freq;
    assign o_freq_changed = r_out_changed;

`ifndef SYNTH
    // remainder results only arrive while the sequencer waits for them
    a_rem_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == ST_MOD1 || r_state == ST_MOD2) |-> !w_rem_done)
        else $error("remainder done outside of a random hop");

    // an accepted word always takes the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // a burst start always leaves the block in the on phase
    a_start_is_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_burst_start |-> o_transmitting)
        else $error("burst start flagged while not transmitting");
`endif

endmodule

// ----- design/dchc_rem.sv -----
// ----------------------------------------------------------------------------
// dchc_rem - iterative remainder unit
// Restoring division, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module dchc_rem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [dchc_pkg::REM_W-1:0] i_dividend,
    input  logic [dchc_pkg::REM_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [dchc_pkg::REM_W-1:0] o_rem
);

    logic                           r_busy;
    logic                           r_done;
    logic [dchc_pkg::REM_CNT_W-1:0] r_cnt;
    logic [dchc_pkg::REM_W-1:0]     r_rem;
    logic [dchc_pkg::REM_W-1:0]     r_dvd;
    logic [dchc_pkg::REM_W-1:0]     r_div;

    logic [dchc_pkg::REM_W:0]   w_cand;
    logic [dchc_pkg::REM_W:0]   w_diff;
    logic                       w_ge;
    logic [dchc_pkg::REM_W-1:0] n_rem;

    // shift in next dividend bit, subtract divisor when it fits
    always_comb begin
        w_cand = {r_rem, r_dvd[dchc_pkg::REM_W-1]};
        w_ge   = w_cand >= {1'b0, r_div};
        w_diff = w_cand - {1'b0, r_div};
        n_rem  = w_ge ? w_diff[dchc_pkg::REM_W-1:0] : w_cand[dchc_pkg::REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= dchc_pkg::REM_CNT_W'(dchc_pkg::REM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[dchc_pkg::REM_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
